[rtl/lz77bp_pkg.sv]
package lz77bp_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned DIST_W  = 11;
  localparam int unsigned REM_W   = 4;
  localparam int unsigned LIT_W   = 4;
  localparam int unsigned DHI_W   = 6;

  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  localparam logic REG_OUT_LIMIT = 1'b0;
  localparam logic [COUNT_W-1:0] OUT_LIMIT_RESET = 16'd4096;

  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_RAW  = 2'd1;
  localparam logic [1:0] MODE_DIST = 2'd2;

  localparam logic [DATA_W-1:0] CMD_RAW_MAX  = 8'h08;
  localparam logic [DATA_W-1:0] CMD_MATCH    = 8'h80;
  localparam logic [DATA_W-1:0] CMD_PAIR     = 8'hc0;
  localparam logic [DATA_W-1:0] DIST_HI_MASK = 8'h3f;
  localparam logic [DATA_W-1:0] DIST_LO_MASK = 8'h1f;
  localparam logic [DATA_W-1:0] LEN_MASK     = 8'h07;
  localparam logic [REM_W-1:0]  LEN_BASE     = 4'd3;
  localparam logic [DATA_W-1:0] PAIR_SPACE   = 8'h20;
  localparam logic [DATA_W-1:0] PAIR_FLIP    = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage

[rtl/lz77_byte_pair_decompressor.sv]
// Decodes one compressed byte per input transfer. A literal emits one byte from S_EMIT, a space
// pair two, a raw-run or back-reference command byte none, and a back reference alternates
// S_READ and S_EMIT for each of its bytes, or emits zeros from S_EMIT alone when its distance is
// invalid; bytes past the output limit are dropped and result stalls hold S_EMIT.
// Each result is registered from S_EMIT, which a valid back reference reaches through S_READ.
// Synchronous active-low reset clears parser and counters; the history is not cleared.
module lz77_byte_pair_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lz77bp_pkg::DATA_W-1:0]   in_byte,
  input  logic                            in_last_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lz77bp_pkg::DATA_W-1:0]   out_byte,
  output logic                            out_run_last,
  output logic                            out_bad_distance,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lz77bp_pkg::CFG_AW-1:0]   paddr,
  input  logic [lz77bp_pkg::CFG_DW-1:0]   pwdata,
  output logic [lz77bp_pkg::CFG_DW-1:0]   prdata,
  output logic                            pready
);
  import lz77bp_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WP_LAST = AW'(HISTORY_DEPTH - 1);

  logic [DATA_W-1:0] hist_mem [HISTORY_DEPTH];

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [LIT_W-1:0]   lit_r, lit_nxt;
  logic [DHI_W-1:0]   dist_hi_r, dist_hi_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] limit_r, limit_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]  byte_r, byte_nxt;
  logic [DATA_W-1:0]  second_r, second_nxt;
  logic               use_mem_r, use_mem_nxt;
  logic               bad_r, bad_nxt;
  logic               last_r, last_nxt;
  logic [DATA_W-1:0]  rd_r;
  logic [DATA_W-1:0]  out_byte_r;
  logic               out_run_last_r;
  logic               out_bad_r;

  logic               cfg_write;
  logic               out_free;
  logic               emit;
  logic               emit_last;
  logic               finish;
  logic               idle_done;
  logic [DATA_W-1:0]  emit_val;
  logic [COUNT_W-1:0] cnt_inc;
  logic [AW-1:0]      wp_inc;
  logic [DIST_W-1:0]  dist_new;
  logic               dist_bad;
  logic [AW:0]        wp_ext;
  logic [AW:0]        dist_ext;
  logic [AW:0]        rd_sum;
  logic [AW-1:0]      rd_addr;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_OUT_LIMIT) ? {{(CFG_DW-COUNT_W){1'b0}}, limit_r} : '0;
  assign limit_nxt = (cfg_write && paddr[2] == REG_OUT_LIMIT) ? pwdata[COUNT_W-1:0] : limit_r;

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_run_last     = out_run_last_r;
  assign out_bad_distance = out_bad_r;

  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_inc   = cnt_r + 16'd1;
  assign wp_inc    = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
  assign emit_val  = use_mem_r ? rd_r : byte_r;
  assign emit_last = (rem_r == 4'd1) || (cnt_inc == limit_r);

  assign dist_new = {dist_hi_r, in_byte[7:3] & DIST_LO_MASK[4:0]};
  assign dist_bad = (dist_new == '0) || ({{(COUNT_W-DIST_W){1'b0}}, dist_new} > cnt_r);

  assign wp_ext   = {1'b0, wp_r};
  assign dist_ext = {{(AW+1-DIST_W){1'b0}}, dist_r};
  assign rd_sum   = wp_ext + ((wp_ext < dist_ext) ? DEPTH_EXT : '0) - dist_ext;
  assign rd_addr  = rd_sum[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    lit_nxt     = lit_r;
    dist_hi_nxt = dist_hi_r;
    wp_nxt      = wp_r;
    cnt_nxt     = cnt_r;
    dist_nxt    = dist_r;
    rem_nxt     = rem_r;
    byte_nxt    = byte_r;
    second_nxt  = second_r;
    use_mem_nxt = use_mem_r;
    bad_nxt     = bad_r;
    last_nxt    = last_r;
    emit        = 1'b0;
    finish      = 1'b0;
    idle_done   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt    = in_last_in;
          bad_nxt     = 1'b0;
          use_mem_nxt = 1'b0;
          rem_nxt     = 4'd1;
          byte_nxt    = in_byte;
          unique case (mode_r)
            MODE_RAW: begin
              lit_nxt   = lit_r - 1'b1;
              if (lit_r == 4'd1) begin
                mode_nxt = MODE_CMD;
              end
              state_nxt = S_EMIT;
            end
            MODE_DIST: begin
              dist_nxt    = dist_new;
              rem_nxt     = {1'b0, in_byte[2:0] & LEN_MASK[2:0]} + LEN_BASE;
              mode_nxt    = MODE_CMD;
              bad_nxt     = dist_bad;
              use_mem_nxt = !dist_bad;
              byte_nxt    = '0;
              state_nxt   = dist_bad ? S_EMIT : S_READ;
            end
            default: begin
              priority if (in_byte != '0 && in_byte <= CMD_RAW_MAX) begin
                lit_nxt   = in_byte[LIT_W-1:0];
                mode_nxt  = MODE_RAW;
                idle_done = 1'b1;
              end else if (in_byte < CMD_MATCH) begin
                state_nxt = S_EMIT;
              end else if (in_byte < CMD_PAIR) begin
                dist_hi_nxt = in_byte[DHI_W-1:0] & DIST_HI_MASK[DHI_W-1:0];
                mode_nxt    = MODE_DIST;
                idle_done   = 1'b1;
              end else begin
                byte_nxt   = PAIR_SPACE;
                second_nxt = in_byte ^ PAIR_FLIP;
                rem_nxt    = 4'd2;
                state_nxt  = S_EMIT;
              end
            end
          endcase
          if (idle_done && in_last_in) begin
            wp_nxt      = '0;
            cnt_nxt     = '0;
            mode_nxt    = MODE_CMD;
            lit_nxt     = '0;
            dist_hi_nxt = '0;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (cnt_r >= limit_r) begin
            finish = 1'b1;
          end else begin
            emit    = 1'b1;
            wp_nxt  = wp_inc;
            cnt_nxt = cnt_inc;
            rem_nxt = rem_r - 1'b1;
            if (emit_last) begin
              finish = 1'b1;
            end else if (use_mem_r) begin
              state_nxt = S_READ;
            end else if (!bad_r) begin
              byte_nxt = second_r;
            end
          end
          if (finish) begin
            state_nxt = S_IDLE;
            if (last_r) begin
              wp_nxt      = '0;
              cnt_nxt     = '0;
              mode_nxt    = MODE_CMD;
              lit_nxt     = '0;
              dist_hi_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_CMD;
      lit_r       <= '0;
      dist_hi_r   <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      limit_r     <= OUT_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      lit_r       <= lit_nxt;
      dist_hi_r   <= dist_hi_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r    <= dist_nxt;
    rem_r     <= rem_nxt;
    byte_r    <= byte_nxt;
    second_r  <= second_nxt;
    use_mem_r <= use_mem_nxt;
    bad_r     <= bad_nxt;
    last_r    <= last_nxt;
    if (emit) begin
      out_byte_r     <= emit_val;
      out_run_last_r <= emit_last;
      out_bad_r      <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[wp_r] <= emit_val;
    end
    if (state_r == S_READ) begin
      rd_r <= hist_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |=> state_r == S_EMIT)
    else $error("history read not followed by an emit cycle");

  a_read_valid_dist: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> (dist_r != '0) && use_mem_r && !bad_r)
    else $error("history read issued for an invalid distance");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_byte_r == '0)
    else $error("flagged back-reference byte is not zero");

  a_raw_pending: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_RAW |-> lit_r != '0)
    else $error("raw mode with no raw bytes left");

  a_busy_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> rem_r != '0)
    else $error("busy with no bytes left to produce");
`endif

endmodule

[tb/sv/lz77_decode_checker.sv]
`timescale 1ns / 100ps

module lz77_decode_checker #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [lz77bp_pkg::DATA_W-1:0]   in_byte,
  input  logic                            in_last_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [lz77bp_pkg::DATA_W-1:0]   out_byte,
  input  logic                            out_run_last,
  input  logic                            out_bad_distance,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lz77bp_pkg::CFG_AW-1:0]   paddr,
  input  logic [lz77bp_pkg::CFG_DW-1:0]   pwdata,
  input  logic [lz77bp_pkg::CFG_DW-1:0]   prdata,
  input  logic                            pready,
  output int                              errors,
  output int                              pending,
  output int                              results_seen,
  output int                              bad_seen
);
  import lz77bp_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              run_last;
    logic              bad;
  } decoded_byte_t;

  decoded_byte_t     decoded_bytes[$];
  decoded_byte_t     burst [10];
  decoded_byte_t     oldest;
  logic [DATA_W-1:0] hist_mem [HISTORY_DEPTH];
  int unsigned       wr_ptr;
  logic [COUNT_W-1:0] emitted;
  logic [COUNT_W-1:0] limit;
  logic [1:0]        mode;
  logic [LIT_W-1:0]  raw_left;
  logic [DHI_W-1:0]  dist_hi;

  task automatic note_mismatch(input string what, input logic [CFG_DW-1:0] got,
                               input logic [CFG_DW-1:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, wanted 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic clear_record();
    wr_ptr   = 0;
    emitted  = '0;
    mode     = MODE_CMD;
    raw_left = '0;
    dist_hi  = '0;
  endtask

  task automatic put_byte(input logic [DATA_W-1:0] v, input logic bad, inout int n);
    if (emitted >= limit) return;
    hist_mem[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1 >= HISTORY_DEPTH) ? 0 : wr_ptr + 1;
    emitted = emitted + 1'b1;
    burst[n] = '{data: v, run_last: 1'b0, bad: bad};
    n++;
  endtask

  task automatic decode_byte(input logic [DATA_W-1:0] b, input logic last);
    logic [DIST_W-1:0] match_dist;
    logic              bad;
    logic [DATA_W-1:0] v;
    int                len;
    int                n;
    int unsigned       idx;
    n = 0;
    case (mode)
      MODE_RAW: begin
        put_byte(b, 1'b0, n);
        raw_left = raw_left - 1'b1;
        if (raw_left == '0) mode = MODE_CMD;
      end
      MODE_DIST: begin
        match_dist = {dist_hi, b[7:3]};
        len  = int'(b & LEN_MASK) + int'(LEN_BASE);
        bad  = (match_dist == '0) || (COUNT_W'(match_dist) > emitted);
        for (int i = 0; i < len; i++) begin
          v = '0;
          if (!bad) begin
            idx = (wr_ptr + HISTORY_DEPTH - int'(match_dist)) % HISTORY_DEPTH;
            v = hist_mem[idx];
          end
          put_byte(v, bad, n);
        end
        mode = MODE_CMD;
      end
      default: begin
        if (b >= 8'd1 && b <= CMD_RAW_MAX) begin
          raw_left = b[LIT_W-1:0];
          mode = MODE_RAW;
        end else if (b < CMD_MATCH) begin
          put_byte(b, 1'b0, n);
        end else if (b < CMD_PAIR) begin
          dist_hi = b[DHI_W-1:0];
          mode = MODE_DIST;
        end else begin
          put_byte(PAIR_SPACE, 1'b0, n);
          put_byte(b ^ PAIR_FLIP, 1'b0, n);
        end
      end
    endcase
    if (n > 0) burst[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) decoded_bytes.push_back(burst[k]);
    if (last) clear_record();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      decoded_bytes.delete();
      clear_record();
      limit = OUT_LIMIT_RESET;
      errors = 0;
      results_seen = 0;
      bad_seen = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_bad_distance) bad_seen++;
        if (decoded_bytes.size() == 0) begin
          note_mismatch("result with nothing pending", CFG_DW'(out_byte), '0);
        end else begin
          oldest = decoded_bytes.pop_front();
          if (out_byte !== oldest.data)
            note_mismatch("out_byte", CFG_DW'(out_byte), CFG_DW'(oldest.data));
          if (out_run_last !== oldest.run_last)
            note_mismatch("out_run_last", CFG_DW'(out_run_last), CFG_DW'(oldest.run_last));
          if (out_bad_distance !== oldest.bad)
            note_mismatch("out_bad_distance", CFG_DW'(out_bad_distance), CFG_DW'(oldest.bad));
        end
      end
      if (in_valid && !in_stall) decode_byte(in_byte, in_last_in);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if ((paddr >> 2) == REG_OUT_LIMIT) limit = pwdata[COUNT_W-1:0];
        end else if (prdata !== CFG_DW'(limit)) begin
          note_mismatch("out_limit read back", prdata, CFG_DW'(limit));
        end
      end
      pending <= decoded_bytes.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lz77bp_pkg::*;

  localparam int unsigned HIST_DEPTH  = 2048;
  localparam int          TAIL_CYCLES = 30;
  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 400;

  typedef struct packed {
    logic [DATA_W-1:0] b;
    logic              last;
  } comp_byte_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [DATA_W-1:0]  in_byte;
  logic               in_last_in;
  logic               out_valid;
  logic               out_stall;
  logic [DATA_W-1:0]  out_byte;
  logic               out_run_last;
  logic               out_bad_distance;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  int errors;
  int pending;
  int results_seen;
  int bad_seen;

  comp_byte_t send_q[$];
  int         bytes_sent;
  int         limit_settings;
  int         cur_limit;
  int         rec_out;
  bit         quiet;
  bit         hold_req;
  bit         hold_done;

  lz77_byte_pair_decompressor #(.HISTORY_DEPTH(HIST_DEPTH)) DUT (.*);

  lz77_decode_checker #(.HISTORY_DEPTH(HIST_DEPTH)) u_checker (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic add_byte(input logic [DATA_W-1:0] b, input logic last);
    send_q.push_back('{b: b, last: last});
  endtask

  task automatic grow_output(input int n);
    rec_out = (rec_out + n > cur_limit) ? cur_limit : rec_out + n;
  endtask

  task automatic add_match(input int d, input int len, input logic last);
    add_byte(CMD_MATCH | DATA_W'(d >> 5), 1'b0);
    add_byte(DATA_W'(((d & 31) << 3) | (len - 3)), last);
    grow_output(len);
  endtask

  task automatic gen_record(input int n_cmds, input bit broken);
    int  pick;
    int  n;
    int  d;
    int  len;
    bit  fin;
    rec_out = 0;
    for (int c = 0; c < n_cmds; c++) begin
      fin  = (c == n_cmds - 1);
      pick = $urandom_range(99);
      if (fin && broken) begin
        if (pick < 35) begin
          add_byte(DATA_W'($urandom_range(1, 8)), 1'b1);
        end else if (pick < 70) begin
          add_byte(CMD_MATCH | DATA_W'($urandom_range(63)), 1'b1);
        end else begin
          n = $urandom_range(2, 8);
          add_byte(DATA_W'(n), 1'b0);
          for (int k = 0; k < n - 1; k++) begin
            add_byte(DATA_W'($urandom_range(255)), k == n - 2);
          end
        end
      end else if (pick < 30) begin
        if ($urandom_range(9) == 0) add_byte(8'h00, fin);
        else add_byte(DATA_W'($urandom_range(9, 127)), fin);
        grow_output(1);
      end else if (pick < 50) begin
        n = $urandom_range(1, 8);
        add_byte(DATA_W'(n), 1'b0);
        for (int k = 0; k < n; k++) begin
          add_byte(DATA_W'($urandom_range(255)), fin && k == n - 1);
        end
        grow_output(n);
      end else if (pick < 85) begin
        len = $urandom_range(3, 10);
        if (rec_out > 0 && $urandom_range(9) != 0) begin
          d = $urandom_range(1, (rec_out < 2047) ? rec_out : 2047);
        end else if (rec_out < 2047 && $urandom_range(1) == 1) begin
          d = $urandom_range(rec_out + 1, 2047);
        end else begin
          d = 0;
        end
        add_match(d, len, fin);
      end else begin
        add_byte(DATA_W'($urandom_range(192, 255)), fin);
        grow_output(2);
      end
    end
  endtask

  task automatic gen_noise(input int n);
    for (int k = 0; k < n; k++) begin
      add_byte(DATA_W'($urandom_range(255)), (k == n - 1) || ($urandom_range(9) == 0));
    end
  endtask

  task automatic gen_mix(input int target);
    int pick;
    while (send_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 80) gen_record($urandom_range(2, 12), 1'b0);
      else if (pick < 90) gen_record($urandom_range(1, 6), 1'b1);
      else gen_noise($urandom_range(3, 12));
    end
  endtask

  task automatic gen_long_record(input int n_match);
    int d;
    int len;
    rec_out = 0;
    add_byte(CMD_RAW_MAX, 1'b0);
    for (int k = 0; k < 8; k++) add_byte(DATA_W'($urandom_range(255)), 1'b0);
    grow_output(8);
    for (int m = 0; m < n_match; m++) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(3, 10) : 10;
      if (rec_out >= 2047 && $urandom_range(7) == 0) d = 2047;
      else d = $urandom_range(1, (rec_out < 2047) ? rec_out : 2047);
      add_match(d, len, m == n_match - 1);
    end
  endtask

  task automatic reg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if ((addr >> 2) == REG_OUT_LIMIT) begin
      cur_limit = int'(data[COUNT_W-1:0]);
      limit_settings++;
    end
  endtask

  task automatic reg_read(input logic [CFG_AW-1:0] addr);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_queued();
    int k;
    bit offered;
    k = 0;
    offered = 1'b0;
    while (k < send_q.size()) begin
      @(posedge clk);
      if (offered && in_valid && !in_stall) begin
        k++;
        bytes_sent++;
        offered = 1'b0;
      end
      if (!offered) begin
        if (k < send_q.size() && (quiet || $urandom_range(99) >= 11)) begin
          in_valid   <= 1'b1;
          in_byte    <= send_q[k].b;
          in_last_in <= send_q[k].last;
          offered = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    send_q.delete();
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= (rst_n && !quiet && $urandom_range(99) < 11);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= '0;
    in_last_in <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    bytes_sent = 0;
    limit_settings = 1;
    cur_limit = int'(OUT_LIMIT_RESET);
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    reg_read('0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(CMD_RAW_MAX, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'hc0, 1'b0);
    add_byte(8'h01, 1'b0);
    add_byte(8'h08, 1'b0);
    add_byte(8'h7f, 1'b0);
    add_byte(8'haa, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(CMD_PAIR, 1'b0);
    add_byte(8'hff, 1'b0);
    add_byte(CMD_MATCH, 1'b0);
    add_byte(8'h08, 1'b0);
    add_byte(CMD_MATCH, 1'b0);
    add_byte(8'h17, 1'b0);
    add_byte(CMD_MATCH, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(CMD_MATCH | DIST_HI_MASK, 1'b0);
    add_byte(8'hff, 1'b1);
    add_byte(8'h03, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(CMD_MATCH | 8'h01, 1'b1);
    send_queued();
    drain();

    reg_write('0, 32'd0);
    reg_read('0);
    gen_mix(15);
    send_queued();
    drain();

    reg_write('0, 32'd5);
    gen_mix(40);
    send_queued();
    drain();

    reg_write(CFG_AW'(4), 32'd3);
    reg_read('0);
    gen_mix(30);
    send_queued();
    drain();

    reg_write('0, 32'd65535);
    reg_read('0);
    quiet = 1'b1;
    gen_long_record(48);
    send_queued();
    quiet = 1'b0;
    drain();

    reg_write('0, CFG_DW'($urandom_range(20, 200)));
    hold_req = 1'b1;
    gen_mix(120);
    send_queued();
    drain();

    reg_write('0, CFG_DW'(OUT_LIMIT_RESET));
    reg_read('0);
    gen_mix(50);
    send_queued();
    drain();

    $display("Decoded %0d compressed bytes under %0d output limits, from zero to full scale.",
             bytes_sent, limit_settings);
    $display("Checked %0d output bytes, %0d of them flagged with a bad distance.",
             results_seen, bad_seen);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/lz77bp_pkg.sv
rtl/lz77_byte_pair_decompressor.sv
tb/sv/lz77_decode_checker.sv
tb/sv/tb_top.sv
